// File: hdl/prg_pkg.sv
// Shared types and codes for the per-channel replay guard.
// No dependencies; used by every module in hdl/.
package prg_pkg;

	// Request codes carried on req_type.
	localparam logic REQ_CHECK  = 1'b0;
	localparam logic REQ_COMMIT = 1'b1;

	// Status codes returned on status.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_STALE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	localparam int CHAN_W = 32;
	localparam int TIME_W = 64;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_FINISH
	} prg_state_t;

	// Result of comparing the request against one table entry.
	typedef struct packed {
		logic chan_eq;
		logic time_gt;
	} prg_cmp_t;

endpackage

// File: hdl/per_channel_replay_guard.sv
// Top level of the per-channel replay guard: sequencer, valid marks, output word.
// Depends on prg_pkg, prg_store and prg_cmp.
//
// Anti-replay table that keeps, for up to SLOTS channels, the last committed
// 64-bit frame timestamp. A check word (req_type 0) answers ok when the channel
// is not in the table or its timestamp is strictly greater than the stored one,
// and stale otherwise; the table is left unchanged. A commit word (req_type 1)
// overwrites the timestamp of the channel's entry, or claims the lowest free
// entry; with no entry free it answers table full and changes nothing. Commit
// does not test ordering itself. Each input word walks every table entry before
// its result is loaded into the output register: one table entry is read per
// cycle through the single read port of the entry store, the shared compare unit
// judges it in the next cycle, and a final state forms the status and performs
// any write. in_ready is high only while the sequencer is idle; the result
// register lets the next word be accepted while the previous result still waits
// on out_ready. Valid marks are cleared by reset, so no clearing pass is needed
// and the block takes words right after reset.
module per_channel_replay_guard #(
	parameter int SLOTS = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [prg_pkg::CHAN_W-1:0]  channel_id,
	input  logic [prg_pkg::TIME_W-1:0]  frame_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status
);

	// Slot index width and walk counter width (the counter must reach SLOTS).
	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam logic [CW-1:0] LAST_CNT = CW'(SLOTS);

	prg_pkg::prg_state_t state_q, state_d;

	// Request latched at acceptance.
	logic                       req_q;
	logic [prg_pkg::CHAN_W-1:0] chan_q;
	logic [prg_pkg::TIME_W-1:0] time_q;

	// Walk bookkeeping.
	logic [CW-1:0] cnt_q;
	logic          cmp_valid_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          found_q;
	logic [IW-1:0] match_idx_q;
	logic          time_gt_q;
	logic          free_found_q;
	logic [IW-1:0] free_idx_q;

	logic [SLOTS-1:0] slot_valid_q;

	logic out_valid_q;
	logic [1:0] status_q;

	// Sequencer outputs.
	logic in_accept;
	logic walk_issue;
	logic walk_done;
	logic fin_load;

	// Store and compare signals.
	logic                       store_we;
	logic [IW-1:0]              store_waddr;
	logic [prg_pkg::CHAN_W-1:0] ent_chan;
	logic [prg_pkg::TIME_W-1:0] ent_time;
	prg_pkg::prg_cmp_t          cmp_res;
	logic [1:0]                 fin_status;

	prg_store #(
		.SLOTS (SLOTS),
		.IW    (IW)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wchan (chan_q),
		.wtime (time_q),
		.raddr (cnt_q[IW-1:0]),
		.rchan (ent_chan),
		.rtime (ent_time)
	);

	prg_cmp u_cmp (
		.key_chan (chan_q),
		.key_time (time_q),
		.ent_chan (ent_chan),
		.ent_time (ent_time),
		.res      (cmp_res)
	);

	// The walk is over once every slot has been issued and the last one judged.
	assign walk_issue = (state_q == prg_pkg::S_WALK) && (cnt_q != LAST_CNT);
	assign walk_done  = (state_q == prg_pkg::S_WALK) && (cnt_q == LAST_CNT) && cmp_valid_s1;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			prg_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = prg_pkg::S_WALK;
				end
			end
			prg_pkg::S_WALK: begin
				if (walk_done) begin
					state_d = prg_pkg::S_FINISH;
				end
			end
			prg_pkg::S_FINISH: begin
				if (!out_valid_q || out_ready) begin
					state_d = prg_pkg::S_IDLE;
				end
			end
			default: state_d = prg_pkg::S_IDLE;
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_ready = 1'b0;
		fin_load = 1'b0;
		unique case (state_q)
			prg_pkg::S_IDLE:   in_ready = 1'b1;
			prg_pkg::S_WALK:   ;
			prg_pkg::S_FINISH: fin_load = !out_valid_q || out_ready;
			default:           ;
		endcase
	end

	assign in_accept = in_valid && in_ready;

	// Status and write target, decided from what the walk found.
	always_comb begin
		fin_status  = prg_pkg::ST_OK;
		store_waddr = found_q ? match_idx_q : free_idx_q;
		store_we    = 1'b0;
		if (req_q == prg_pkg::REQ_CHECK) begin
			if (found_q && !time_gt_q) begin
				fin_status = prg_pkg::ST_STALE;
			end
		end else begin
			if (found_q || free_found_q) begin
				store_we = fin_load;
			end else begin
				fin_status = prg_pkg::ST_FULL;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= prg_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Latch the request word.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			req_q  <= req_type;
			chan_q <= channel_id;
			time_q <= frame_time;
		end
	end

	// Walk over the slots: issue one read per cycle, judge it the next cycle.
	// Only the first valid match and the first invalid slot are kept.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_idx_s1   <= '0;
			found_q      <= 1'b0;
			match_idx_q  <= '0;
			time_gt_q    <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
		end else if (in_accept) begin
			cnt_q        <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			cmp_valid_s1 <= walk_issue;
			if (walk_issue) begin
				cmp_idx_s1 <= cnt_q[IW-1:0];
				cnt_q      <= cnt_q + CW'(1);
			end
			if (cmp_valid_s1) begin
				if (slot_valid_q[cmp_idx_s1]) begin
					if (cmp_res.chan_eq && !found_q) begin
						found_q     <= 1'b1;
						match_idx_q <= cmp_idx_s1;
						time_gt_q   <= cmp_res.time_gt;
					end
				end else if (!free_found_q) begin
					free_found_q <= 1'b1;
					free_idx_q   <= cmp_idx_s1;
				end
			end
		end
	end

	// Valid marks: set together with the entry write of a commit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
		end else if (store_we) begin
			slot_valid_q[store_waddr] <= 1'b1;
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_load) begin
			status_q <= fin_status;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;

endmodule

// File: hdl/prg_store.sv
// Entry storage for the replay guard: channel and timestamp per slot.
// One write port, one read port with registered read data. Uses prg_pkg.
module prg_store #(
	parameter int SLOTS = 8,
	parameter int IW    = 3
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IW-1:0]               waddr,
	input  logic [prg_pkg::CHAN_W-1:0]  wchan,
	input  logic [prg_pkg::TIME_W-1:0]  wtime,
	input  logic [IW-1:0]               raddr,
	output logic [prg_pkg::CHAN_W-1:0]  rchan,
	output logic [prg_pkg::TIME_W-1:0]  rtime
);

	logic [prg_pkg::CHAN_W-1:0] chan_mem [SLOTS];
	logic [prg_pkg::TIME_W-1:0] time_mem [SLOTS];

	always_ff @(posedge clk) begin
		if (we) begin
			chan_mem[waddr] <= wchan;
			time_mem[waddr] <= wtime;
		end
	end

	always_ff @(posedge clk) begin
		rchan <= chan_mem[raddr];
		rtime <= time_mem[raddr];
	end

endmodule

// File: hdl/prg_cmp.sv
// Shared compare unit: channel equality and strict timestamp ordering.
// Uses prg_pkg for widths and the result struct.
module prg_cmp (
	input  logic [prg_pkg::CHAN_W-1:0] key_chan,
	input  logic [prg_pkg::TIME_W-1:0] key_time,
	input  logic [prg_pkg::CHAN_W-1:0] ent_chan,
	input  logic [prg_pkg::TIME_W-1:0] ent_time,
	output prg_pkg::prg_cmp_t          res
);

	always_comb begin
		res.chan_eq = (key_chan == ent_chan);
		res.time_gt = (key_time > ent_time);
	end

endmodule
